[rtl/event_journal_ring_unit_macros.svh]
// Assertion macros used by the event journal checker.
`ifndef EVENT_JOURNAL_RING_UNIT_MACROS_SVH
`define EVENT_JOURNAL_RING_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EJR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EJR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ejr_pkg.sv]
// Shared types and request codes for the event journal.
package ejr_pkg;

	// Request codes
	localparam logic [1:0] REQ_SAVE  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam int NUM_W  = 11;
	localparam int CNT_W  = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	// One journal record as held in memory (60 bits)
	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             unread;
		logic [31:0]      stamp;
		logic [7:0]       code;
		logic [7:0]       arg;
	} entry_t;

endpackage

[rtl/ejr_mem.sv]
// Journal record memory: one write port, one registered read port.
module ejr_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  ejr_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output ejr_pkg::entry_t rd_data
);
	import ejr_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/event_journal_ring_unit.sv]
// Top level of the event journal ring.
//
// Each item is handled in steps: in the accept cycle (IDLE) the journal memory is
// read at the requested record, and in the BUSY state the entry is modified and
// written back while the result register is loaded; the next item is taken only
// once BUSY returns to IDLE, so no new item is accepted before the last is through,
// set by the read-modify-write of the single journal memory. A result held by a
// stalled consumer keeps BUSY waiting until the result register frees up.
// The memory is not swept after reset: entries beyond the fill mark read back as
// all zero with no unread mark, so items are accepted as soon as reset is released.
module event_journal_ring_unit #(
	parameter int DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  event_code,
	input  logic [7:0]  event_arg,
	input  logic [31:0] time_now,
	input  logic [15:0] record_sel,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [10:0] rec_number,
	output logic [31:0] rec_time,
	output logic [7:0]  rec_code,
	output logic [7:0]  rec_arg,
	output logic [10:0] total_saved,
	output logic [15:0] unread_total
);
	import ejr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(DEPTH + 1);
	localparam logic [15:0] SEL_MAX = 16'(DEPTH);
	localparam logic [PW-1:0] POS_MAX = PW'(DEPTH);
	localparam logic [PW-1:0] POS_ONE = PW'(1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic state_q;

	// architectural state
	logic [PW-1:0]    write_pos_q;
	logic             full_q;
	logic [CNT_W-1:0] unread_q;
	logic [7:0]       last_code_q;
	logic [7:0]       last_arg_q;

	// stage 1 item
	logic [1:0]    req_s1;
	logic [7:0]    code_s1;
	logic [7:0]    arg_s1;
	logic [31:0]   time_s1;
	logic [AW-1:0] addr_s1;

	// result register
	logic             rsp_valid_q;
	logic [10:0]      num_q;
	logic [31:0]      time_q;
	logic [7:0]       code_q;
	logic [7:0]       arg_q;
	logic [10:0]      saved_q;
	logic [CNT_W-1:0] unread_out_q;

	logic          accept;
	logic          go;
	logic [15:0]   sel_idx;
	logic [AW-1:0] rd_addr;
	entry_t        rd_entry;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;

	logic             is_save;
	logic             dup;
	logic             do_save;
	logic             entry_ok;
	logic             do_read;
	logic [PW-1:0]    pos_inc;
	logic [PW-1:0]    pos_less;
	logic [PW+10:0]   pos_ext;
	logic [PW+10:0]   cur_ext;
	logic [PW-1:0]    pos_nx;
	logic [CNT_W-1:0] unread_nx;
	entry_t           rd_view;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign go        = (state_q == ST_BUSY) && (!rsp_valid_q || rsp_ready);

	// clamp the record select onto a memory index
	always_comb begin
		if (record_sel > SEL_MAX) begin
			sel_idx = SEL_MAX - 16'd1;
		end else if (record_sel == 16'd0) begin
			sel_idx = 16'd0;
		end else begin
			sel_idx = record_sel - 16'd1;
		end
	end
	assign rd_addr = sel_idx[AW-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_BUSY;
				ST_BUSY: if (go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			code_s1 <= event_code;
			arg_s1  <= event_arg;
			time_s1 <= time_now;
			addr_s1 <= rd_addr;
		end
	end

	// save path: next write position, wrapping from DEPTH to 1
	assign is_save  = (req_s1 == REQ_SAVE);
	assign dup      = (code_s1 == last_code_q) && (arg_s1 == last_arg_q);
	assign do_save  = go && is_save && !dup;
	assign pos_inc  = (write_pos_q == POS_MAX) ? POS_ONE : write_pos_q + POS_ONE;
	assign pos_less = pos_inc - POS_ONE;
	assign pos_ext  = {11'd0, pos_inc};
	assign cur_ext  = {11'd0, pos_nx};

	// read path: entries past the fill mark were never written
	assign entry_ok = full_q || (PW'(addr_s1) < write_pos_q);
	assign do_read  = go && (req_s1 == REQ_READ);
	assign rd_view  = entry_ok ? rd_entry : '0;

	// memory write: a new record, or the unread mark cleared on read
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = rd_entry;
		if (do_save) begin
			mem_we           = 1'b1;
			mem_waddr        = pos_less[AW-1:0];
			mem_wdata.number = pos_ext[10:0];
			mem_wdata.unread = 1'b1;
			mem_wdata.stamp  = time_s1;
			mem_wdata.code   = code_s1;
			mem_wdata.arg    = arg_s1;
		end else if (do_read && entry_ok) begin
			mem_we           = 1'b1;
			mem_wdata.unread = 1'b0;
		end
	end

	// next position and unread count
	always_comb begin
		pos_nx    = write_pos_q;
		unread_nx = unread_q;
		case (req_s1)
			REQ_SAVE: begin
				if (!dup) begin
					pos_nx = pos_inc;
					if (unread_q != CNT_MAX) unread_nx = unread_q + 16'd1;
				end
			end
			REQ_READ: begin
				if (rd_view.unread && unread_q != '0) unread_nx = unread_q - 16'd1;
			end
			REQ_CLEAR: unread_nx = '0;
			default: ;
		endcase
	end

	// state update at the end of the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			full_q      <= 1'b0;
			unread_q    <= '0;
			last_code_q <= '0;
			last_arg_q  <= '0;
		end else if (go) begin
			write_pos_q <= pos_nx;
			unread_q    <= unread_nx;
			if (do_save) begin
				last_code_q <= code_s1;
				last_arg_q  <= arg_s1;
				if (pos_inc == POS_MAX) full_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (req_s1 == REQ_READ) begin
				num_q  <= rd_view.number;
				time_q <= rd_view.stamp;
				code_q <= rd_view.code;
				arg_q  <= rd_view.arg;
			end else begin
				num_q  <= '0;
				time_q <= '0;
				code_q <= '0;
				arg_q  <= '0;
			end
			saved_q      <= cur_ext[10:0];
			unread_out_q <= unread_nx;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rec_number   = num_q;
	assign rec_time     = time_q;
	assign rec_code     = code_q;
	assign rec_arg      = arg_q;
	assign total_saved  = saved_q;
	assign unread_total = unread_out_q;

	ejr_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_entry)
	);

endmodule

[rtl/ejr_checker.sv]
// Port-level checks for the event journal, bound to the top level.
`include "event_journal_ring_unit_macros.svh"

module ejr_checker #(
	parameter int DEPTH = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [10:0] rec_number,
	input logic [31:0] rec_time,
	input logic [7:0]  rec_code,
	input logic [7:0]  rec_arg,
	input logic [10:0] total_saved,
	input logic [15:0] unread_total
);

	// a stalled result stays put
	`EJR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rec_time) && $stable(unread_total) && $stable(total_saved), "stalled result changed")

	// one item at a time: no accept right after an accept
	`EJR_ASSERT_NEXT(a_one_busy, clk, arst_n, req_valid && req_ready, !req_ready, "item accepted while busy")

	// the write position never runs past the ring
	`EJR_ASSERT_NOW(a_pos_range, clk, arst_n, rsp_valid, (DEPTH >= 2048) || (total_saved <= 11'(DEPTH)), "write position beyond depth")

	// record number zero means an empty or non-read result
	`EJR_ASSERT_NOW(a_empty_rec, clk, arst_n, rsp_valid && (rec_number == 11'd0), (rec_time == 32'd0) && (rec_code == 8'd0) && (rec_arg == 8'd0), "record zero with payload")

endmodule

bind event_journal_ring_unit ejr_checker #(.DEPTH(DEPTH)) u_ejr_checker (.*);
